// File: rtl/core/mag_dec_pkg.sv
`timescale 1ns / 1ps

package mag_dec_pkg;

  localparam int MAX_FLAG_BYTES = 128;
  localparam int HISTORY_ROWS   = 17;
  localparam int COL_W          = 8;
  localparam int PTR_W          = $clog2(HISTORY_ROWS);
  localparam int HIST_STRIDE    = 2 ** COL_W;
  localparam int HIST_DEPTH     = HISTORY_ROWS * HIST_STRIDE;
  localparam int HIST_AW        = $clog2(HIST_DEPTH);
  localparam int FLAG_AW        = $clog2(MAX_FLAG_BYTES);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_ROWS - 1);

  localparam logic [2:0] OFF_DX [16] = '{
    3'd0, 3'd1, 3'd2, 3'd4, 3'd0, 3'd1, 3'd0, 3'd1,
    3'd2, 3'd0, 3'd1, 3'd2, 3'd0, 3'd1, 3'd2, 3'd0
  };
  localparam logic [4:0] OFF_DY [16] = '{
    5'd0, 5'd0, 5'd0, 5'd0, 5'd1, 5'd1, 5'd2, 5'd2,
    5'd2, 5'd4, 5'd4, 5'd4, 5'd8, 5'd8, 5'd8, 5'd16
  };

  localparam logic CFG_FLAG_BYTES = 1'b0;
  localparam logic CFG_IMAGE_ROWS = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNEXP    = 2'd1;
  localparam logic [1:0] ST_MISSING  = 2'd2;
  localparam logic [1:0] ST_PAST_END = 2'd3;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_PIXEL,
    SRC_COPY,
    SRC_ZERO
  } src_e;

  typedef struct packed {
    logic        req_type;
    logic        flag_a_bit;
    logic [7:0]  flag_b_byte;
    logic [15:0] pixel_word;
  } item_t;

  typedef struct packed {
    logic        unit_valid;
    logic [15:0] unit_word;
    logic [7:0]  unit_col;
    logic [15:0] unit_row;
    logic        need_pixel;
    logic        image_done;
    logic [1:0]  status;
    logic        last;
  } unit_t;

  typedef struct packed {
    src_e               src;
    logic [15:0]        word;
    logic [HIST_AW-1:0] raddr;
    logic [HIST_AW-1:0] waddr;
    logic [COL_W-1:0]   col;
    logic [15:0]        row;
    logic               need_pixel;
    logic               done;
    logic [1:0]         status;
    logic               last;
  } op_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [15:0]      row;
    logic [PTR_W-1:0] ptr;
    logic             done;
  } pos_t;

  typedef struct packed {
    logic               zero;
    logic [HIST_AW-1:0] addr;
  } copy_t;

  function automatic pos_t advance(pos_t p, logic [8:0] upr, logic [16:0] rtot);
    pos_t n;
    n = p;
    if ({1'b0, p.col} + 9'd1 >= upr) begin
      n.col = '0;
      if ({1'b0, p.row} + 17'd1 >= rtot) begin
        n.done = 1'b1;
      end else begin
        n.row = p.row + 16'd1;
        n.ptr = (p.ptr == PTR_LAST) ? '0 : p.ptr + PTR_W'(1);
      end
    end else begin
      n.col = p.col + COL_W'(1);
    end
    return n;
  endfunction

  function automatic copy_t copy_src(logic [3:0] nib, pos_t p);
    copy_t      c;
    logic [2:0] dx;
    logic [4:0] dy;
    logic [5:0] s;
    logic [COL_W-1:0] sx;
    dx = OFF_DX[nib];
    dy = OFF_DY[nib];
    s  = 6'({1'b0, p.ptr}) + 6'(HISTORY_ROWS) - 6'(dy);
    if (s >= 6'(HISTORY_ROWS)) begin
      s = s - 6'(HISTORY_ROWS);
    end
    sx     = p.col - COL_W'(dx);
    c.zero = (p.col < COL_W'(dx)) || (p.row < 16'(dy));
    c.addr = HIST_AW'({s[PTR_W-1:0], sx});
    return c;
  endfunction

  function automatic op_t mk_unit(src_e src, logic [15:0] pw, copy_t c, pos_t at,
                                  logic done_after);
    op_t o;
    o.src        = (src == SRC_COPY && c.zero) ? SRC_ZERO : src;
    o.word       = pw;
    o.raddr      = c.addr;
    o.waddr      = HIST_AW'({at.ptr, at.col});
    o.col        = at.col;
    o.row        = at.row;
    o.need_pixel = 1'b0;
    o.done       = done_after;
    o.status     = ST_OK;
    o.last       = 1'b1;
    return o;
  endfunction

  function automatic op_t mk_status(logic [1:0] st, logic done, logic need);
    op_t o;
    o.src        = SRC_NONE;
    o.word       = '0;
    o.raddr      = '0;
    o.waddr      = '0;
    o.col        = '0;
    o.row        = '0;
    o.need_pixel = need;
    o.done       = done;
    o.status     = st;
    o.last       = 1'b1;
    return o;
  endfunction

endpackage

// File: rtl/core/mag_dec_if.sv
`timescale 1ns / 1ps

interface mag_dec_in_if import mag_dec_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mag_dec_out_if import mag_dec_pkg::*; ();
  logic  valid;
  logic  ready;
  unit_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/mag_dec_ram.sv
`timescale 1ns / 1ps

module mag_dec_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/mag_dec_front.sv
`timescale 1ns / 1ps

module mag_dec_front import mag_dec_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  mag_dec_in_if.sink  in_i,
  input  logic        room2_i,
  output op_t         op0_o,
  output op_t         op1_o,
  output logic [1:0]  push_cnt_o
);

  logic [7:0]       fbpr_q;
  logic [15:0]      rows_q;
  logic [COL_W-1:0] col_q;
  logic [15:0]      row_q;
  logic [PTR_W-1:0] ptr_q;
  logic             done_q;
  logic [7:0]       nib_q, nib_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             fhit_q;
  logic [7:0]       fwd_q;

  logic       acc;
  logic [7:0] fbpr_eff;
  logic [8:0] upr;
  logic [16:0] rtot;
  pos_t       cur, a1, a2, nxt, pos_d;
  copy_t      c0, c1;
  logic [7:0] prev, b, flag_rdata;
  logic [3:0] nib1;
  logic       e1, flag_we;
  op_t        op0, op1;
  logic [1:0] push_cnt;

  assign in_i.ready = room2_i;
  assign acc        = in_i.valid && in_i.ready;

  assign fbpr_eff = (fbpr_q == 8'd0) ? 8'd1 :
                    (fbpr_q > 8'(MAX_FLAG_BYTES)) ? 8'(MAX_FLAG_BYTES) : fbpr_q;
  assign upr      = {fbpr_eff, 1'b0};
  assign rtot     = (rows_q == 16'd0) ? 17'd1 : {1'b0, rows_q};

  assign cur  = '{col: col_q, row: row_q, ptr: ptr_q, done: done_q};
  assign a1   = advance(cur, upr, rtot);
  assign a2   = advance(a1, upr, rtot);
  assign prev = fhit_q ? fwd_q : flag_rdata;
  assign b    = (in_i.data.flag_a_bit ? in_i.data.flag_b_byte : 8'd0) ^
                ((row_q != 16'd0) ? prev : 8'd0);
  assign nib1 = in_i.data.req_type ? nib_q[3:0] : b[3:0];
  assign c0   = copy_src(b[7:4], cur);
  assign c1   = copy_src(nib1, a1);

  always_comb begin
    nxt      = cur;
    cnt_d    = cnt_q;
    nib_d    = nib_q;
    flag_we  = 1'b0;
    e1       = 1'b0;
    push_cnt = 2'd0;
    op0      = mk_status(ST_OK, done_q, 1'b0);
    op1      = mk_unit(SRC_COPY, 16'd0, c1, a1, a2.done);
    if (acc) begin
      push_cnt = 2'd1;
      if (done_q) begin
        op0 = mk_status(ST_PAST_END, 1'b1, 1'b0);
      end else if (in_i.data.req_type) begin
        if (cnt_q == 2'd0) begin
          op0 = mk_status(ST_UNEXP, 1'b0, 1'b0);
        end else begin
          e1  = (cnt_q == 2'd2) && !a1.done && (nib1 != 4'd0);
          op0 = mk_unit(SRC_PIXEL, in_i.data.pixel_word, c0, cur, a1.done);
          if (e1) begin
            nxt   = a2;
            cnt_d = 2'd0;
          end else begin
            nxt   = a1;
            cnt_d = cnt_q - 2'd1;
          end
        end
      end else begin
        if (cnt_q != 2'd0) begin
          op0 = mk_status(ST_MISSING, 1'b0, 1'b1);
        end else begin
          flag_we = 1'b1;
          nib_d   = b;
          if (b[7:4] == 4'd0) begin
            op0   = mk_status(ST_OK, 1'b0, 1'b1);
            cnt_d = 2'd2;
          end else begin
            e1  = !a1.done && (b[3:0] != 4'd0);
            op0 = mk_unit(SRC_COPY, 16'd0, c0, cur, a1.done);
            if (e1) begin
              nxt   = a2;
              cnt_d = 2'd0;
            end else begin
              nxt   = a1;
              cnt_d = 2'd1;
            end
          end
        end
      end
      if (nxt.done) begin
        cnt_d = 2'd0;
      end
      if (op0.src != SRC_NONE) begin
        op0.need_pixel = (cnt_d != 2'd0) && !nxt.done;
      end
      op1.need_pixel = (cnt_d != 2'd0) && !nxt.done;
      op0.last       = !e1;
      if (e1) begin
        push_cnt = 2'd2;
      end
    end
  end

  always_comb begin
    pos_d = nxt;
    if (cfg_we_i) begin
      pos_d = '0;
    end
  end

  assign op0_o      = op0;
  assign op1_o      = op1;
  assign push_cnt_o = push_cnt;

  mag_dec_ram #(
    .WIDTH (8),
    .DEPTH (MAX_FLAG_BYTES)
  ) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (flag_we),
    .waddr_i (col_q[COL_W-1 -: FLAG_AW]),
    .wdata_i (b),
    .re_i    (1'b1),
    .raddr_i (pos_d.col[COL_W-1 -: FLAG_AW]),
    .rdata_o (flag_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fbpr_q <= 8'd1;
      rows_q <= 16'd1;
      col_q  <= '0;
      row_q  <= '0;
      ptr_q  <= '0;
      done_q <= 1'b0;
      nib_q  <= '0;
      cnt_q  <= '0;
      fhit_q <= 1'b0;
    end else begin
      fhit_q <= flag_we &&
                (col_q[COL_W-1 -: FLAG_AW] == pos_d.col[COL_W-1 -: FLAG_AW]);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FLAG_BYTES: fbpr_q <= cfg_data_i[7:0];
          CFG_IMAGE_ROWS: rows_q <= cfg_data_i;
          default: ;
        endcase
        nib_q <= '0;
        cnt_q <= '0;
      end else begin
        nib_q <= nib_d;
        cnt_q <= cnt_d;
      end
      col_q  <= pos_d.col;
      row_q  <= pos_d.row;
      ptr_q  <= pos_d.ptr;
      done_q <= pos_d.done;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_q <= b;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("pending nibble count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> cnt_q == 2'd0)
    else $error("nibbles pending after image end");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q == 2'd0 |-> !col_q[0])
    else $error("flag slot boundary lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   {1'b0, col_q} < upr || $past(cfg_we_i))
    else $error("column beyond row end");

endmodule

// File: rtl/core/mag_dec_fifo.sv
`timescale 1ns / 1ps

module mag_dec_fifo import mag_dec_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  op_t        op0_i,
  input  op_t        op1_i,
  input  logic [1:0] push_cnt_i,
  output logic       room2_o,
  output logic       valid_o,
  output op_t        head_o,
  input  logic       pop_i
);

  op_t        mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;
  logic       pop;

  assign pop     = pop_i && valid_o;
  assign valid_o = cnt_q != 3'd0;
  assign room2_o = cnt_q <= 3'd2;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + push_cnt_i;
      rd_q  <= rd_q + 2'(pop);
      cnt_q <= cnt_q + 3'(push_cnt_i) - 3'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_q] <= op0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_q + 2'd1] <= op1_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   push_cnt_i != 2'd0 |-> $past(room2_o) || cnt_q <= 3'd2)
    else $error("push without room");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   cnt_q == 3'd0 |-> wr_q == rd_q)
    else $error("queue pointers disagree");

endmodule

// File: rtl/core/mag_dec_back.sv
`timescale 1ns / 1ps

module mag_dec_back import mag_dec_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  op_t           head_i,
  output logic          pop_o,
  mag_dec_out_if.source out_o
);

  op_t         s1_q;
  logic        s1_v_q;
  logic        hit_q;
  logic [15:0] fwd_q;
  logic        out_v_q;
  unit_t       out_q;

  logic        out_adv, s1_adv, pop, hist_we;
  logic [15:0] s1_word, rdata;

  assign out_adv = !out_v_q || out_o.ready;
  assign s1_adv  = !s1_v_q || out_adv;
  assign pop     = valid_i && s1_adv;
  assign pop_o   = pop;
  assign hist_we = s1_v_q && out_adv && (s1_q.src != SRC_NONE);

  always_comb begin
    case (s1_q.src)
      SRC_PIXEL: s1_word = s1_q.word;
      SRC_COPY:  s1_word = hit_q ? fwd_q : rdata;
      default:   s1_word = 16'd0;
    endcase
  end

  mag_dec_ram #(
    .WIDTH (16),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (s1_q.waddr),
    .wdata_i (s1_word),
    .re_i    (pop),
    .raddr_i (head_i.raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_q <= pop;
      end
      if (out_adv) begin
        out_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_q  <= head_i;
      hit_q <= hist_we && (head_i.raddr == s1_q.waddr);
      fwd_q <= s1_word;
    end
    if (out_adv) begin
      out_q.unit_valid <= s1_q.src != SRC_NONE;
      out_q.unit_word  <= s1_word;
      out_q.unit_col   <= s1_q.col;
      out_q.unit_row   <= s1_q.row;
      out_q.need_pixel <= s1_q.need_pixel;
      out_q.image_done <= s1_q.done;
      out_q.status     <= s1_q.status;
      out_q.last       <= s1_q.last;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> s1_adv)
    else $error("pop while stage held");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   s1_v_q && !out_adv |=> s1_v_q && $stable(s1_q))
    else $error("stalled stage lost its op");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   hist_we |-> s1_q.status == ST_OK)
    else $error("history written by a status result");

endmodule

// File: rtl/core/mag_image_unit_decoder.sv
`timescale 1ns / 1ps
// Path: an accepted item is queued, then held in the history read stage, then in the output register.
// Throughput: one result per cycle while the output is ready; a flag slot that decodes two units queues two results.
// The history memory read and the queue of up to four results set the rate.
// Reset: configuration returns to one flag byte and one row, decoding restarts at row 0;
// flag and history memories are not cleared.
module mag_image_unit_decoder import mag_dec_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [15:0]   cfg_data_i,
  mag_dec_in_if.sink    in_i,
  mag_dec_out_if.source out_o
);

  op_t        op0, op1, head;
  logic [1:0] push_cnt;
  logic       room2, q_valid, pop;

  mag_dec_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .room2_i    (room2),
    .op0_o      (op0),
    .op1_o      (op1),
    .push_cnt_o (push_cnt)
  );

  mag_dec_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op0_i      (op0),
    .op1_i      (op1),
    .push_cnt_i (push_cnt),
    .room2_o    (room2),
    .valid_o    (q_valid),
    .head_o     (head),
    .pop_i      (pop)
  );

  mag_dec_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
